// ===== design/spsba_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab page slot allocator package
// Command codes, status codes and register indexes shared by the allocator.
// ----------------------------------------------------------------------------
package spsba_pkg;

    localparam int WORD_BITS    = 64;
    localparam int SLOT_W       = 8;
    localparam int CNT_W        = 9;
    localparam int SLOT_CEILING = 256;

    typedef enum logic [2:0] {
        CMD_ALLOC     = 3'd0,
        CMD_FREE      = 3'd1,
        CMD_MARK_HOT  = 3'd2,
        CMD_MARK_COLD = 3'd3,
        CMD_CLEAR_HOT = 3'd4,
        CMD_QUERY     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    // Register index as decoded from paddr[2].
    localparam logic REG_SLOT_LIMIT = 1'b0;

endpackage

// ===== design/slab_page_slot_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab page slot bitmap allocator
// Allocation and hot bitmaps for one slab page, with a word-serial free-slot
// scanner, a used count and a hot count.
// ----------------------------------------------------------------------------
// Sequence: an alloc scans the 64-bit words of the map for a free slot, grants it,
//   then scans again to see whether the page is now full; the second scan
//   restarts at the granted word. A free scans once; all other commands go
//   straight to the finishing state.
// Flow: one command at a time; the scanner uses the single 64-bit word compare
//   once per cycle, and the finishing state holds while the previous result beat
//   waits for m_tready. Reset: synchronous,
//   active low; bitmaps, counts and output register clear, slot_limit is 256.
module slab_page_slot_bitmap_allocator #(
    parameter int MAP_WORDS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Command channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] cmd, [10:3] slot_index, [15:11] zero

    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] status, [9:2] granted_slot,
                                   // [18:10] used_slots, [27:19] hot_slots,
                                   // [28] slot_is_hot, [29] became_full,
                                   // [30] became_partial, [31] became_empty

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import spsba_pkg::*;

    // Word index width, and the width used to compare a candidate slot with the limit.
    localparam int WA        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CAND_W    = WA + 6;
    localparam int CMP_W     = (CAND_W > CNT_W) ? CAND_W : CNT_W;
    localparam int CAP_SLOTS = MAP_WORDS * WORD_BITS;

    // The sequencer has three states: waiting for a beat, scanning the allocation
    // map one word per cycle, and finishing, which applies the update and loads
    // the result register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Lowest set bit of a 64-bit word; the scanner feeds it the inverted map word.
    function automatic logic [5:0] lowest_set(input logic [63:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (v[b]) begin
                idx = 6'(b);
            end
        end
        return idx;
    endfunction

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SLOT_W-1:0] tgt_reg, tgt_next;
    logic [WA-1:0]     scan_w_reg, scan_w_next;
    logic              pass_reg, pass_next;
    logic              fail_reg, fail_next;
    logic              full_reg, full_next;
    logic              was_full_reg, was_full_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  hot_cnt_reg, hot_cnt_next;
    logic [CNT_W-1:0]  limit_reg, limit_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic [WORD_BITS-1:0] alloc_map_reg [MAP_WORDS];
    logic [WORD_BITS-1:0] hot_map_reg   [MAP_WORDS];

    // Bitmap write controls from the sequencer.
    logic                 alloc_wr_en;
    logic [WA-1:0]        alloc_wr_addr;
    logic [WORD_BITS-1:0] alloc_wr_data;
    logic                 hot_wr_en;
    logic                 hot_clear;
    logic [WORD_BITS-1:0] hot_wr_data;

    // Scanner datapath: one allocation word per cycle.
    logic [CNT_W-1:0]     eff_limit;
    logic [WORD_BITS-1:0] scan_word;
    logic [WORD_BITS-1:0] scan_inv;
    logic                 scan_hit;
    logic [5:0]           scan_bit;
    logic [CAND_W-1:0]    cand;
    logic                 cand_ok;
    logic                 scan_last;

    // Addressed slot: the command's slot, or the granted slot after an alloc.
    logic [WA-1:0]        tgt_w;
    logic                 tgt_in_cap;
    logic [WORD_BITS-1:0] tgt_aword;
    logic [WORD_BITS-1:0] tgt_hword;
    logic [WORD_BITS-1:0] tgt_mask;
    logic                 tgt_abit;
    logic                 tgt_hbit;

    // Result fields built in the finishing cycle.
    status_t          r_status;
    logic [SLOT_W-1:0] r_granted;
    logic             r_is_hot;
    logic             r_full;
    logic             r_part;
    logic             r_empty;
    logic [CNT_W-1:0] used_dec;

    logic cfg_write;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration access: one register, always ready.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SLOT_LIMIT);
    assign prdata    = (paddr[2] == REG_SLOT_LIMIT) ? {23'd0, limit_reg} : 32'd0;

    // The effective limit is clipped to 256; the map capacity bounds candidates by itself.
    assign eff_limit = (limit_reg > CNT_W'(SLOT_CEILING)) ? CNT_W'(SLOT_CEILING) : limit_reg;

    assign scan_word = alloc_map_reg[scan_w_reg];
    assign scan_inv  = ~scan_word;
    assign scan_hit  = |scan_inv;
    assign scan_bit  = lowest_set(scan_inv);
    assign cand      = {scan_w_reg, scan_bit};
    // The first word with a clear bit ends the scan; if that bit lies at or
    // beyond the limit, the page counts as full.
    assign cand_ok   = scan_hit && (CMP_W'(cand) < CMP_W'(eff_limit));
    assign scan_last = (scan_w_reg == WA'(MAP_WORDS - 1));

    assign tgt_w      = WA'(tgt_reg[7:6]);
    assign tgt_in_cap = (int'(tgt_reg) < CAP_SLOTS);
    assign tgt_aword  = alloc_map_reg[tgt_w];
    assign tgt_hword  = hot_map_reg[tgt_w];
    assign tgt_mask   = 64'd1 << tgt_reg[5:0];
    assign tgt_abit   = tgt_aword[tgt_reg[5:0]];
    assign tgt_hbit   = tgt_hword[tgt_reg[5:0]];
    assign used_dec   = (used_reg == '0) ? '0 : used_reg - CNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        tgt_next      = tgt_reg;
        scan_w_next   = scan_w_reg;
        pass_next     = pass_reg;
        fail_next     = fail_reg;
        full_next     = full_reg;
        was_full_next = was_full_reg;
        used_next     = used_reg;
        hot_cnt_next  = hot_cnt_reg;
        limit_next    = cfg_write ? pwdata[CNT_W-1:0] : limit_reg;
        m_tvalid_next = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        alloc_wr_en   = 1'b0;
        alloc_wr_addr = tgt_w;
        alloc_wr_data = tgt_aword & ~tgt_mask;
        hot_wr_en     = 1'b0;
        hot_clear     = 1'b0;
        hot_wr_data   = tgt_hword;

        r_status  = STATUS_OK;
        r_granted = '0;
        r_is_hot  = 1'b0;
        r_full    = 1'b0;
        r_part    = 1'b0;
        r_empty   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next      = cmd_t'(s_tdata[2:0]);
                    tgt_next      = s_tdata[10:3];
                    scan_w_next   = '0;
                    pass_next     = 1'b0;
                    fail_next     = 1'b0;
                    full_next     = 1'b0;
                    was_full_next = 1'b0;
                    if (s_tdata[2:0] inside {CMD_ALLOC, CMD_FREE}) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    if (cmd_reg == CMD_ALLOC && !pass_reg) begin
                        if (cand_ok) begin
                            // Grant the slot, then rescan from the same word
                            // to see whether the page is now full.
                            alloc_wr_en   = 1'b1;
                            alloc_wr_addr = scan_w_reg;
                            alloc_wr_data = scan_word | (64'd1 << scan_bit);
                            used_next     = (used_reg == '1) ? used_reg
                                                             : used_reg + CNT_W'(1);
                            tgt_next      = SLOT_W'(cand);
                            pass_next     = 1'b1;
                        end else begin
                            fail_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                    end else if (cmd_reg == CMD_ALLOC) begin
                        full_next  = !cand_ok;
                        state_next = S_FINISH;
                    end else begin
                        was_full_next = !cand_ok;
                        state_next    = S_FINISH;
                    end
                end else begin
                    scan_w_next = scan_w_reg + WA'(1);
                end
            end

            S_FINISH: begin
                case (cmd_reg)
                    CMD_ALLOC: begin
                        if (fail_reg) begin
                            r_status = STATUS_FULL;
                        end else begin
                            r_granted = tgt_reg;
                            r_is_hot  = tgt_hbit;
                            r_full    = full_reg;
                        end
                    end
                    CMD_FREE: begin
                        if (!tgt_in_cap || !tgt_abit) begin
                            r_status = STATUS_BAD;
                            r_is_hot = tgt_in_cap && tgt_hbit;
                        end else begin
                            alloc_wr_en = 1'b1;
                            used_next   = used_dec;
                            r_part      = was_full_reg;
                            r_empty     = (used_dec == '0);
                            r_is_hot    = tgt_hbit;
                        end
                    end
                    CMD_MARK_HOT, CMD_MARK_COLD: begin
                        if (!tgt_in_cap) begin
                            r_status = STATUS_BAD;
                        end else begin
                            hot_wr_en = 1'b1;
                            if (cmd_reg == CMD_MARK_HOT) begin
                                hot_wr_data = tgt_hword | tgt_mask;
                                r_is_hot    = 1'b1;
                                if (!tgt_hbit) begin
                                    hot_cnt_next = hot_cnt_reg + CNT_W'(1);
                                end
                            end else begin
                                hot_wr_data = tgt_hword & ~tgt_mask;
                                if (tgt_hbit) begin
                                    hot_cnt_next = hot_cnt_reg - CNT_W'(1);
                                end
                            end
                        end
                    end
                    CMD_CLEAR_HOT: begin
                        hot_clear    = 1'b1;
                        hot_cnt_next = '0;
                    end
                    default: begin
                        // Query, and the unused codes behave as a query.
                        if (!tgt_in_cap) begin
                            r_status = STATUS_BAD;
                        end else begin
                            r_is_hot = tgt_hbit;
                            if (!tgt_abit) begin
                                r_status = STATUS_BAD;
                            end
                        end
                    end
                endcase

                // Hold the update until the result register is free.
                if (m_tvalid_reg && !m_tready) begin
                    alloc_wr_en  = 1'b0;
                    hot_wr_en    = 1'b0;
                    hot_clear    = 1'b0;
                    used_next    = used_reg;
                    hot_cnt_next = hot_cnt_reg;
                end else begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {r_empty, r_part, r_full, r_is_hot,
                                     hot_cnt_next, used_next, r_granted, r_status};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_QUERY;
            tgt_reg      <= '0;
            scan_w_reg   <= '0;
            pass_reg     <= 1'b0;
            fail_reg     <= 1'b0;
            full_reg     <= 1'b0;
            was_full_reg <= 1'b0;
            used_reg     <= '0;
            hot_cnt_reg  <= '0;
            limit_reg    <= CNT_W'(SLOT_CEILING);
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            for (int i = 0; i < MAP_WORDS; i++) begin
                alloc_map_reg[i] <= '0;
                hot_map_reg[i]   <= '0;
            end
        end else begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            tgt_reg      <= tgt_next;
            scan_w_reg   <= scan_w_next;
            pass_reg     <= pass_next;
            fail_reg     <= fail_next;
            full_reg     <= full_next;
            was_full_reg <= was_full_next;
            used_reg     <= used_next;
            hot_cnt_reg  <= hot_cnt_next;
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            if (alloc_wr_en) begin
                alloc_map_reg[alloc_wr_addr] <= alloc_wr_data;
            end
            if (hot_clear) begin
                for (int i = 0; i < MAP_WORDS; i++) begin
                    hot_map_reg[i] <= '0;
                end
            end else if (hot_wr_en) begin
                hot_map_reg[tgt_w] <= hot_wr_data;
            end
        end
    end

endmodule

// ===== tb/slot_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// Slot allocator result checker
// Watches the command, result and register ports of the slab page slot
// allocator, keeps its own copy of the page state, works out the result of
// every accepted command and compares it with the next result beat.
// ----------------------------------------------------------------------------
module slot_allocator_checker #(
    parameter int MAP_WORDS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [31:0]       m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int unsigned       fail_count,
    output int unsigned       pending
);
    import spsba_pkg::*;

    localparam int CAP        = MAP_WORDS * WORD_BITS;
    localparam int LIMIT_CEIL = (CAP < SLOT_CEILING) ? CAP : SLOT_CEILING;

    // Packed so that it lines up with m_tdata, first field in the top bit.
    typedef struct packed {
        logic               became_empty;
        logic               became_partial;
        logic               became_full;
        logic               slot_is_hot;
        logic [CNT_W-1:0]   hot_slots;
        logic [CNT_W-1:0]   used_slots;
        logic [SLOT_W-1:0]  granted_slot;
        status_t            status;
    } slot_result_t;

    logic [CAP-1:0]   alloc_bits;
    logic [CAP-1:0]   hot_bits;
    logic [CNT_W-1:0] used_cnt;
    logic [CNT_W-1:0] limit_reg;
    int unsigned      failures = 0;
    slot_result_t     expected_results[$];

    // Lowest clear allocation bit, or -1 when it lies at or above the limit.
    function automatic int first_free_below_limit();
        int cap_lim;
        cap_lim = (limit_reg > LIMIT_CEIL) ? LIMIT_CEIL : int'(limit_reg);
        for (int i = 0; i < CAP; i++) begin
            if (!alloc_bits[i]) return (i < cap_lim) ? i : -1;
        end
        return -1;
    endfunction

    function automatic logic [CNT_W-1:0] count_hot();
        int n;
        n = 0;
        for (int i = 0; i < CAP; i++) n += int'(hot_bits[i]);
        return n[CNT_W-1:0];
    endfunction

    // Applies one command to the page state and returns its result.
    function automatic slot_result_t apply_command(input logic [2:0] cmd,
                                                   input logic [SLOT_W-1:0] slot);
        slot_result_t r;
        int           f;
        logic         in_cap;
        r = '0;
        in_cap = (int'(slot) < CAP);
        case (cmd)
            CMD_ALLOC: begin
                f = first_free_below_limit();
                if (f < 0) begin
                    r.status = STATUS_FULL;
                end else begin
                    alloc_bits[f] = 1'b1;
                    if (used_cnt != '1) used_cnt = used_cnt + CNT_W'(1);
                    r.granted_slot = f[SLOT_W-1:0];
                    r.slot_is_hot  = hot_bits[f];
                    r.became_full  = (first_free_below_limit() < 0);
                end
            end
            CMD_FREE: begin
                if (!in_cap || !alloc_bits[slot]) begin
                    r.status = STATUS_BAD;
                    if (in_cap) r.slot_is_hot = hot_bits[slot];
                end else begin
                    r.became_partial = (first_free_below_limit() < 0);
                    alloc_bits[slot] = 1'b0;
                    if (used_cnt != '0) used_cnt = used_cnt - CNT_W'(1);
                    r.became_empty = (used_cnt == '0);
                    r.slot_is_hot  = hot_bits[slot];
                end
            end
            CMD_MARK_HOT, CMD_MARK_COLD: begin
                if (!in_cap) begin
                    r.status = STATUS_BAD;
                end else begin
                    hot_bits[slot] = (cmd == CMD_MARK_HOT);
                    r.slot_is_hot  = hot_bits[slot];
                end
            end
            CMD_CLEAR_HOT: begin
                hot_bits = '0;
            end
            default: begin
                // Query, and the two unused codes behave as a query too.
                if (!in_cap) begin
                    r.status = STATUS_BAD;
                end else begin
                    r.slot_is_hot = hot_bits[slot];
                    if (!alloc_bits[slot]) r.status = STATUS_BAD;
                end
            end
        endcase
        r.used_slots = used_cnt;
        r.hot_slots  = count_hot();
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        slot_result_t seen;
        slot_result_t want;
        if (!aresetn) begin
            alloc_bits = '0;
            hot_bits   = '0;
            used_cnt   = '0;
            limit_reg  = CNT_W'(SLOT_CEILING);
            expected_results.delete();
        end else begin
            // A result beat always belongs to an earlier command, so it is
            // matched before a command accepted on the same edge is queued.
            if (m_tvalid && m_tready) begin
                seen = slot_result_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing outstanding: %h", m_tdata);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", int'(want.status), int'(seen.status));
                    check_field("granted_slot", int'(want.granted_slot),
                                int'(seen.granted_slot));
                    check_field("used_slots", int'(want.used_slots),
                                int'(seen.used_slots));
                    check_field("hot_slots", int'(want.hot_slots), int'(seen.hot_slots));
                    check_field("slot_is_hot", int'(want.slot_is_hot),
                                int'(seen.slot_is_hot));
                    check_field("became_full", int'(want.became_full),
                                int'(seen.became_full));
                    check_field("became_partial", int'(want.became_partial),
                                int'(seen.became_partial));
                    check_field("became_empty", int'(want.became_empty),
                                int'(seen.became_empty));
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_SLOT_LIMIT)
                limit_reg = pwdata[CNT_W-1:0];
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_command(s_tdata[2:0], s_tdata[10:3]));
        end
        pending    <= expected_results.size();
        fail_count <= failures;
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Slab page slot allocator testbench
// Drives commands and slot limit writes into the allocator with random gaps
// and back-pressure; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import spsba_pkg::*;

    localparam int MAP_WORDS    = 4;
    // Far beyond the slowest legal run: under 500 commands, each with its scan
    // in the block plus a random gap and stall.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles allowed after the last expected beat for a stray one to show up.
    localparam int DRAIN_CYCLES = 2 * MAP_WORDS + 6;

    // The slot limit register is selected by paddr[2].
    localparam logic [2:0] LIMIT_ADDR = {REG_SLOT_LIMIT, 2'b00};

    // Command codes the package leaves unnamed; the block treats them as a query.
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;

    // Remaining length of a stretch without gaps, one per side.
    int send_calm = 0;
    int recv_calm = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    slab_page_slot_bitmap_allocator #(
        .MAP_WORDS (MAP_WORDS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    slot_allocator_checker #(
        .MAP_WORDS (MAP_WORDS)
    ) result_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Draws how many cycles a side idles before its next beat. Now and then
    // a stretch of back-to-back beats is started, so that the block also
    // sees runs with no idling at all.
    task automatic draw_wait(inout int calm_left, output int cycles);
        if (calm_left > 0) begin
            calm_left--;
            cycles = 0;
        end else begin
            if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(10, 40);
            cycles = $urandom_range(0, 11);
        end
    endtask

    // Result side: stalls for a random number of cycles, then takes one beat.
    // The ready flag is only lowered when a stall is drawn, so a zero stall
    // leaves it high across consecutive beats.
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            draw_wait(recv_calm, stall);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Sends one command beat after a random gap and returns at the edge at
    // which it is accepted. Valid stays high into the next call when no gap
    // is drawn, so back-to-back beats see a single assignment per edge.
    task automatic send_command(input logic [2:0] code, input logic [7:0] slot);
        int gap;
        draw_wait(send_calm, gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, slot, code};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Writes the slot limit once the block is idle. The checker's outstanding
    // count is registered, hence the edge taken before the test.
    task automatic write_slot_limit(input logic [8:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random command. Allocations pack the page from slot zero upwards,
    // so most addressed slots are drawn from zero to just above the current
    // limit, where frees and queries actually hit allocated slots.
    task automatic random_command(input int alloc_pct, input int free_pct,
                                  input int span);
        int          roll;
        logic [2:0]  code;
        logic [7:0]  slot;
        roll = $urandom_range(0, 99);
        slot = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) slot = 8'($urandom_range(0, span));
        if (roll < alloc_pct)
            code = CMD_ALLOC;
        else if (roll < alloc_pct + free_pct)
            code = CMD_FREE;
        else
            code = 3'($urandom_range(CMD_MARK_HOT, CMD_UNUSED_HI));
        send_command(code, slot);
    endtask

    task automatic run_phase(input int limit, input int count,
                             input int alloc_pct, input int free_pct);
        int span;
        span = (limit + 2 > 255) ? 255 : limit + 2;
        write_slot_limit(9'(limit));
        repeat (count) random_command(alloc_pct, free_pct, span);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset limit: status on an empty page, hot
        // marks on unallocated slots, alloc keeping the hot bit, a free
        // that empties the page, a repeated free at a used count of zero,
        // the unused command codes and clearing all hot bits.
        send_command(CMD_QUERY, 8'd0);
        send_command(CMD_FREE, 8'd255);
        send_command(CMD_MARK_HOT, 8'd0);
        send_command(CMD_MARK_HOT, 8'd255);
        send_command(CMD_ALLOC, 8'd0);
        send_command(CMD_ALLOC, 8'd255);
        send_command(CMD_QUERY, 8'd1);
        send_command(CMD_MARK_COLD, 8'd0);
        send_command(CMD_FREE, 8'd1);
        send_command(CMD_FREE, 8'd0);
        send_command(CMD_FREE, 8'd0);
        send_command(CMD_UNUSED_LO, 8'd255);
        send_command(CMD_UNUSED_HI, 8'd0);
        send_command(CMD_CLEAR_HOT, 8'd170);

        // Two usable slots: fill the page, alloc on a full page, and a free
        // that leaves it partial again.
        write_slot_limit(9'd2);
        send_command(CMD_ALLOC, 8'd0);
        send_command(CMD_ALLOC, 8'd0);
        send_command(CMD_ALLOC, 8'd0);
        send_command(CMD_FREE, 8'd1);
        send_command(CMD_ALLOC, 8'd0);

        // Lowering the limit strands slot one above it; it can still be freed.
        write_slot_limit(9'd1);
        send_command(CMD_FREE, 8'd1);
        send_command(CMD_FREE, 8'd0);

        // A limit of zero makes the page permanently full.
        write_slot_limit(9'd0);
        send_command(CMD_ALLOC, 8'd0);
        send_command(CMD_MARK_HOT, 8'd85);

        // A limit above the capacity is clipped to the capacity.
        write_slot_limit(9'd511);
        send_command(CMD_ALLOC, 8'd0);
        send_command(CMD_FREE, 8'd0);

        // Random part. The first phase is nearly all allocs, to fill the
        // whole page up to slot 255; later phases drain it under lower
        // limits and then refill with a mixed load.
        run_phase(256, 270, 92, 4);
        run_phase(130, 50, 20, 60);
        run_phase(9, 40, 50, 35);
        run_phase(1, 25, 50, 35);
        run_phase(65, 35, 60, 25);
        run_phase(256, 30, 35, 35);

        // Wait for every outstanding result, then a few more cycles in case
        // the block produces a beat that nobody asked for.
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
